FILE: rtl/core/crps_pkg.sv
// Shared types and constants of the PI clock-rate servo.
// No dependencies; compiled first.
`default_nettype none
package crps_pkg;

  localparam int unsigned MUL_A_W = 64;
  localparam int unsigned MUL_B_W = 32;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int unsigned DIV_N_W = 80;
  localparam int unsigned DIV_D_W = 48;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 40;

  localparam logic [19:0] PPM_SCALE = 20'd1000000;

  localparam logic [30:0] THR_RST     = 31'd1000000;
  localparam logic [19:0] KP_RST      = 20'd45875;
  localparam logic [19:0] KI_RST      = 20'd19661;
  localparam logic [9:0]  LIM_RST     = 10'd100;
  localparam logic [39:0] NOMINAL_RST = 40'd4294967296;
  localparam logic [23:0] PER_PPM_RST = 24'd4295;
  localparam logic [39:0] FLOOR_RST   = 40'd4294537796;
  localparam logic [39:0] CEIL_RST    = 40'd4295396796;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_THRESHOLD = 3'd0,
    CFG_PROP_GAIN      = 3'd1,
    CFG_INTEG_GAIN     = 3'd2,
    CFG_RATE_LIMIT     = 3'd3,
    CFG_RATE_NOMINAL   = 3'd4,
    CFG_RATE_PER_PPM   = 3'd5,
    CFG_RATE_FLOOR     = 3'd6,
    CFG_RATE_CEILING   = 3'd7
  } cfg_idx_e;

  typedef enum logic {
    FUNC_UPDATE = 1'b0,
    FUNC_CLEAR  = 1'b1
  } func_e;

  typedef struct packed {
    logic               func;
    logic signed [31:0] error_ns;
    logic [31:0]        sample_period;
  } in_item_t;

  typedef struct packed {
    logic [39:0] rate_word;
    logic        step_request;
  } out_item_t;

endpackage
`default_nettype wire

FILE: rtl/core/crps_if.sv
// Valid/ready channel interfaces for servo input and result transactions.
// Depends on crps_pkg.
`default_nettype none
interface crps_in_if;
  logic               valid;
  logic               ready;
  crps_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface crps_out_if;
  logic                valid;
  logic                ready;
  crps_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/crps_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle, MSB first.
// Depends on crps_pkg.
`default_nettype none
module crps_mul (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [crps_pkg::MUL_A_W-1:0]  a_i,
  input  wire logic [crps_pkg::MUL_B_W-1:0]  b_i,
  output      logic                          done_o,
  output      logic [crps_pkg::MUL_P_W-1:0]  prod_o
);
  import crps_pkg::*;

  localparam int unsigned CNT_W = $clog2(MUL_B_W);

  logic [MUL_A_W-1:0] a_q;
  logic [MUL_B_W-1:0] b_q;
  logic [MUL_P_W-1:0] acc_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               busy_q;
  logic               done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(MUL_B_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= (acc_q << 1) + (b_q[MUL_B_W-1] ? MUL_P_W'(a_q) : '0);
      b_q   <= b_q << 1;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule
`default_nettype wire

FILE: rtl/core/crps_div.sv
// Bit-serial restoring divider, one quotient bit per cycle, truncating.
// Depends on crps_pkg.
`default_nettype none
module crps_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [crps_pkg::DIV_N_W-1:0]  num_i,
  input  wire logic [crps_pkg::DIV_D_W-1:0]  den_i,
  output      logic                          done_o,
  output      logic [crps_pkg::DIV_N_W-1:0]  quot_o
);
  import crps_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIV_N_W);

  logic [DIV_N_W-1:0] num_q;
  logic [DIV_D_W-1:0] den_q;
  logic [DIV_D_W:0]   rem_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               busy_q;
  logic               done_q;

  logic [DIV_D_W:0] trial;
  logic             fits;

  assign trial = {rem_q[DIV_D_W-1:0], num_q[DIV_N_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DIV_N_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // quotient bits shift in behind the numerator
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? (trial - {1'b0, den_q}) : trial;
      num_q <= {num_q[DIV_N_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule
`default_nettype wire

FILE: rtl/core/clock_rate_pi_servo_top.sv
// PI clock-rate servo with anti-windup and step detection, top level.
// Depends on crps_pkg, crps_if, crps_mul and crps_div.
//
//   channel  dir  payload                          handshake
//   in_i     in   func, error_ns, sample_period    valid/ready
//   out_o    out  rate_word, step_request          valid/ready
//   cfg      in   cfg_idx_i, cfg_data_i            cfg_we_i, no back-pressure
//
// One item at a time. A clear transaction completes at its accepting edge and
// ready stays high. A confirmed step puts the nominal rate word with
// step_request set into the result register at acceptance and moves it to the
// output register once that is free; ready returns as it is loaded. A normal
// update runs a sequencer over a shared bit-serial multiplier (7 products) and
// a shared bit-serial divider (3 quotients) plus the clip, absolute-value and
// total steps, and then moves its result to the output register the same way.
// Input ready is high only while the sequencer is idle; the output
// register lets the next transaction be taken while a result waits on out_o,
// and the sequencer holds its result until that register is free.
// Reset clears controller state, counters and configuration to defaults.
`default_nettype none
module clock_rate_pi_servo_top #(
  parameter int unsigned STEP_CONFIRM = 3
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [crps_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [crps_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  crps_in_if.sink                               in_i,
  crps_out_if.source                            out_o
);
  import crps_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_KP_GAIN, ST_KP_SCALE, ST_KP_DIV, ST_KI_INC, ST_BND_NUM,
    ST_BND_DEN, ST_BND_DIV, ST_CLIP, ST_ABS, ST_KI_MUL, ST_KI_DIV,
    ST_TOTAL, ST_RATE, ST_OUT
  } state_e;

  // configuration
  logic [30:0] thr_q;
  logic [19:0] kp_gain_q;
  logic [19:0] ki_gain_q;
  logic [9:0]  lim_q;
  logic [39:0] nominal_q;
  logic [23:0] per_ppm_q;
  logic [39:0] floor_q;
  logic [39:0] ceil_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q     <= THR_RST;
      kp_gain_q <= KP_RST;
      ki_gain_q <= KI_RST;
      lim_q     <= LIM_RST;
      nominal_q <= NOMINAL_RST;
      per_ppm_q <= PER_PPM_RST;
      floor_q   <= FLOOR_RST;
      ceil_q    <= CEIL_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_STEP_THRESHOLD: thr_q     <= cfg_data_i[30:0];
        CFG_PROP_GAIN:      kp_gain_q <= cfg_data_i[19:0];
        CFG_INTEG_GAIN:     ki_gain_q <= cfg_data_i[19:0];
        CFG_RATE_LIMIT:     lim_q     <= cfg_data_i[9:0];
        CFG_RATE_NOMINAL:   nominal_q <= cfg_data_i;
        CFG_RATE_PER_PPM:   per_ppm_q <= cfg_data_i[23:0];
        CFG_RATE_FLOOR:     floor_q   <= cfg_data_i;
        CFG_RATE_CEILING:   ceil_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // shared arithmetic units
  logic                 mul_start_q, mul_done;
  logic [MUL_A_W-1:0]   mul_a_q;
  logic [MUL_B_W-1:0]   mul_b_q;
  logic [MUL_P_W-1:0]   mul_p;
  logic                 div_start_q, div_done;
  logic [DIV_N_W-1:0]   div_n_q;
  logic [DIV_D_W-1:0]   div_d_q;
  logic [DIV_N_W-1:0]   div_q;

  crps_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start_q),
    .a_i     (mul_a_q),
    .b_i     (mul_b_q),
    .done_o  (mul_done),
    .prod_o  (mul_p)
  );

  crps_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start_q),
    .num_i   (div_n_q),
    .den_i   (div_d_q),
    .done_o  (div_done),
    .quot_o  (div_q)
  );

  // sequencer state
  state_e             state_q;
  logic signed [63:0] integ_q;
  logic [7:0]         over_q;
  logic [31:0]        mag_q;
  logic               neg_q;
  logic [31:0]        per_q;
  logic signed [57:0] kp_q;
  logic [41:0]        bnum_q;
  logic [57:0]        bound_q;
  logic               ineg_q;
  logic signed [10:0] ki_q;
  logic               tneg_q;
  out_item_t          res_q;
  logic               out_valid_q;
  out_item_t          out_q;

  // accept-cycle decode
  logic        in_fire;
  logic [31:0] err_u;
  logic [31:0] mag_c;
  logic        over_c;
  logic [7:0]  over_inc;
  logic        step_c;
  logic        out_load;

  assign in_fire  = in_i.valid && in_i.ready;
  assign err_u    = in_i.data.error_ns;
  assign mag_c    = err_u[31] ? (~err_u + 32'd1) : err_u;
  assign over_c   = mag_c > {1'b0, thr_q};
  assign over_inc = (over_q == 8'hFF) ? 8'hFF : over_q + 8'd1;
  assign step_c   = over_inc >= 8'(STEP_CONFIRM);
  // result moves into the output register once that register is free
  assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_o.ready);

  // datapath terms used inside single states
  logic [63:0]        kd64;
  logic signed [63:0] bnd64;
  logic signed [63:0] integ_clip;
  logic [63:0]        integ_abs;
  logic [57:0]        kp_mag;
  logic [9:0]         ki_mag;
  logic signed [57:0] sum_c;
  logic signed [57:0] lim58;
  logic [9:0]         tot_mag;
  logic               tot_neg;
  logic signed [41:0] rate_raw;
  logic signed [41:0] rate_flr;
  logic signed [41:0] rate_fin;

  always_comb begin
    kd64  = {28'b0, mul_p[51:16]};
    bnd64 = {6'b0, bound_q};
    if (integ_q > bnd64) begin
      integ_clip = bnd64;
    end else if (integ_q < -bnd64) begin
      integ_clip = -bnd64;
    end else begin
      integ_clip = integ_q;
    end
    integ_abs = integ_q[63] ? (~integ_q + 64'd1) : integ_q;
    kp_mag    = {1'b0, div_q[56:0]};
    ki_mag    = (div_q > DIV_N_W'(lim_q)) ? lim_q : div_q[9:0];
    lim58     = {48'b0, lim_q};
    sum_c     = kp_q + {{47{ki_q[10]}}, ki_q};
    if (sum_c > lim58) begin
      tot_mag = lim_q;
      tot_neg = 1'b0;
    end else if (sum_c < -lim58) begin
      tot_mag = lim_q;
      tot_neg = 1'b1;
    end else begin
      tot_mag = sum_c[57] ? (~sum_c[9:0] + 10'd1) : sum_c[9:0];
      tot_neg = sum_c[57];
    end
    rate_raw = tneg_q ? ({2'b0, nominal_q} - {8'b0, mul_p[33:0]})
                      : ({2'b0, nominal_q} + {8'b0, mul_p[33:0]});
    // floor first, then ceiling, so the ceiling wins when they cross
    rate_flr = (rate_raw < $signed({2'b0, floor_q})) ? $signed({2'b0, floor_q}) : rate_raw;
    rate_fin = (rate_flr > $signed({2'b0, ceil_q})) ? $signed({2'b0, ceil_q}) : rate_flr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      integ_q     <= '0;
      over_q      <= '0;
      out_valid_q <= 1'b0;
      mul_start_q <= 1'b0;
      div_start_q <= 1'b0;
    end else begin
      mul_start_q <= 1'b0;
      div_start_q <= 1'b0;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            if (func_e'(in_i.data.func) == FUNC_CLEAR) begin
              integ_q <= '0;
              over_q  <= '0;
            end else begin
              mag_q <= mag_c;
              neg_q <= err_u[31];
              per_q <= (in_i.data.sample_period == 32'd0) ? 32'd1 : in_i.data.sample_period;
              if (over_c) begin
                over_q <= over_inc;
              end else begin
                over_q <= '0;
              end
              if (over_c && step_c) begin
                res_q.rate_word    <= nominal_q;
                res_q.step_request <= 1'b1;
                state_q            <= ST_OUT;
              end else begin
                mul_a_q     <= 64'(mag_c);
                mul_b_q     <= 32'(kp_gain_q);
                mul_start_q <= 1'b1;
                state_q     <= ST_KP_GAIN;
              end
            end
          end
        end
        ST_KP_GAIN: begin
          if (mul_done) begin
            mul_a_q     <= mul_p[63:0];
            mul_b_q     <= 32'(PPM_SCALE);
            mul_start_q <= 1'b1;
            state_q     <= ST_KP_SCALE;
          end
        end
        ST_KP_SCALE: begin
          // (x >> 16) / period equals x / (period << 16)
          if (mul_done) begin
            div_n_q     <= {16'b0, mul_p[79:16]};
            div_d_q     <= 48'(per_q);
            div_start_q <= 1'b1;
            state_q     <= ST_KP_DIV;
          end
        end
        ST_KP_DIV: begin
          if (div_done) begin
            kp_q        <= neg_q ? -$signed(kp_mag) : $signed(kp_mag);
            mul_a_q     <= 64'(mag_q);
            mul_b_q     <= 32'(ki_gain_q);
            mul_start_q <= 1'b1;
            state_q     <= ST_KI_INC;
          end
        end
        ST_KI_INC: begin
          if (mul_done) begin
            integ_q     <= integ_q + $signed(neg_q ? (~kd64 + 64'd1) : kd64);
            mul_a_q     <= 64'(lim_q);
            mul_b_q     <= per_q;
            mul_start_q <= 1'b1;
            state_q     <= ST_BND_NUM;
          end
        end
        ST_BND_NUM: begin
          if (mul_done) begin
            bnum_q      <= mul_p[41:0];
            mul_a_q     <= 64'(ki_gain_q);
            mul_b_q     <= 32'(PPM_SCALE);
            mul_start_q <= 1'b1;
            state_q     <= ST_BND_DEN;
          end
        end
        ST_BND_DEN: begin
          if (mul_done) begin
            div_n_q     <= {22'b0, bnum_q, 16'b0};
            div_d_q     <= mul_p[47:0];
            div_start_q <= 1'b1;
            state_q     <= ST_BND_DIV;
          end
        end
        ST_BND_DIV: begin
          // zero integral gain pins the integrator at zero
          if (div_done) begin
            bound_q <= (ki_gain_q == 20'd0) ? 58'd0 : div_q[57:0];
            state_q <= ST_CLIP;
          end
        end
        ST_CLIP: begin
          integ_q <= integ_clip;
          state_q <= ST_ABS;
        end
        ST_ABS: begin
          ineg_q      <= integ_q[63];
          mul_a_q     <= integ_abs;
          mul_b_q     <= 32'(PPM_SCALE);
          mul_start_q <= 1'b1;
          state_q     <= ST_KI_MUL;
        end
        ST_KI_MUL: begin
          if (mul_done) begin
            div_n_q     <= mul_p[79:0];
            div_d_q     <= 48'(per_q);
            div_start_q <= 1'b1;
            state_q     <= ST_KI_DIV;
          end
        end
        ST_KI_DIV: begin
          if (div_done) begin
            ki_q    <= ineg_q ? -$signed({1'b0, ki_mag}) : $signed({1'b0, ki_mag});
            state_q <= ST_TOTAL;
          end
        end
        ST_TOTAL: begin
          tneg_q      <= tot_neg;
          mul_a_q     <= 64'(tot_mag);
          mul_b_q     <= 32'(per_ppm_q);
          mul_start_q <= 1'b1;
          state_q     <= ST_RATE;
        end
        ST_RATE: begin
          if (mul_done) begin
            res_q.rate_word    <= rate_fin[39:0];
            res_q.step_request <= 1'b0;
            state_q            <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            out_q   <= res_q;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_i.ready  = (state_q == ST_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule
`default_nettype wire
